// File: hdl/sidtab_pkg.sv
// Package for the sorted ID table: sizes, operation codes and the structs
// that travel between the cells of the chain. No dependencies.
package sidtab_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ID_W        = 32;
  localparam int FUNC_W      = 2;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // Insert command broadcast to every cell.
  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] id;
  } ins_t;

  // What a cell shows its right-hand neighbor during an insert.
  typedef struct packed {
    logic            valid;
    logic            gt;     // entry is empty or greater than the new id
    logic [ID_W-1:0] id;
  } link_t;

  // Query token that walks the chain one cell per cycle.
  typedef struct packed {
    logic            act;
    logic            done;
    logic [ID_W-1:0] cand;
  } tok_t;

endpackage

// File: hdl/sidtab_if.sv
// Handshake channels of the sorted ID table: request and response.
// Depends on sidtab_pkg for the field widths.
interface sidtab_req_if import sidtab_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   used_id;

  modport source (output valid, output func, output used_id, input ready);
  modport sink   (input valid, input func, input used_id, output ready);
endinterface

interface sidtab_rsp_if import sidtab_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] free_id;
  logic            status;

  modport source (output valid, output free_id, output status, input ready);
  modport sink   (input valid, input free_id, input status, output ready);
endinterface

// File: hdl/sidtab_cell.sv
// One cell of the sorted ID table chain: holds one entry, takes part in the
// parallel insertion step and passes the query token on. Uses sidtab_pkg.
module sidtab_cell import sidtab_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  clear,
  input  ins_t  ins,
  input  link_t left,
  output link_t right,
  input  tok_t  tok_in,
  output tok_t  tok_out
);

  logic            valid;
  logic [ID_W-1:0] id;
  logic            stop;

  assign right.valid = valid;
  assign right.id    = id;
  assign right.gt    = !valid || (id > ins.id);

  // Stop the walk here when the entry is empty or leaves a gap below it.
  assign stop = tok_in.done || !valid || (tok_in.cand < id);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (ins.en) begin
      if (left.gt) begin
        valid <= left.valid;
      end else if (right.gt) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins.en) begin
      if (left.gt) begin
        id <= left.id;
      end else if (right.gt) begin
        id <= ins.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.act <= 1'b0;
    end else begin
      tok_out.act <= tok_in.act;
    end
    tok_out.done <= stop;
    tok_out.cand <= stop ? tok_in.cand : id + ID_W'(1);
  end

endmodule

// File: hdl/sorted_id_table_lowest_free.sv
// Sorted ID table with lowest-free-ID query, built as a chain of cells.
// Clear, insert and unused codes: accepted, result in the next cycle. Query:
// a token walks the chain one cell per cycle, then the output register takes
// its candidate. One item at a time, each result transferred before the next.
// Reset (rst, synchronous) empties the table and drops any pending result.
module sorted_id_table_lowest_free import sidtab_pkg::*; (
  input logic            clk,
  input logic            rst,
  sidtab_req_if.sink     req,
  sidtab_rsp_if.source   rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WAIT = 1'b1;

  logic             state;
  logic [CNT_W-1:0] count;
  logic             full;
  logic             acc;
  logic             out_valid;
  logic [ID_W-1:0]  out_free_id;
  logic             out_status;

  ins_t  ins;
  logic  clear;
  link_t link [TABLE_DEPTH+1];
  tok_t  tok  [TABLE_DEPTH+1];

  assign full      = (count == CNT_W'(TABLE_DEPTH));
  // Take a new item only when idle and the last result has been transferred.
  assign req.ready = (state == ST_IDLE) && !out_valid;
  assign acc       = req.valid && req.ready;

  assign clear  = acc && (req.func == FUNC_CLEAR);
  assign ins.en = acc && (req.func == FUNC_INSERT) && !full;
  assign ins.id = req.used_id;

  // Left end of the chain: nothing to shift in, never greater.
  assign link[0].valid = 1'b0;
  assign link[0].gt    = 1'b0;
  assign link[0].id    = '0;

  // Inject a query token with the first candidate, 1.
  assign tok[0].act  = acc && (req.func == FUNC_QUERY);
  assign tok[0].done = 1'b0;
  assign tok[0].cand = ID_W'(1);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sidtab_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear),
      .ins     (ins),
      .left    (link[i]),
      .right   (link[i+1]),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // Entry count tracks the number of valid cells.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
    end else if (ins.en) begin
      count <= count + CNT_W'(1);
    end
  end

  // Hold in WAIT while the query token walks the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (tok[0].act) state <= ST_WAIT;
        ST_WAIT: if (tok[TABLE_DEPTH].act) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: load on a finished item, drop on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tok[TABLE_DEPTH].act || (acc && (req.func != FUNC_QUERY))) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok[TABLE_DEPTH].act) begin
      out_free_id <= tok[TABLE_DEPTH].cand;
      out_status  <= 1'b0;
    end else if (acc) begin
      out_free_id <= '0;
      out_status  <= (req.func == FUNC_INSERT) && full;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.free_id = out_free_id;
  assign rsp.status  = out_status;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    acc && (req.func == FUNC_INSERT) && full |=> $stable(count) && out_status)
    else $error("insert into full table changed the count or missed status");

  a_token_exit: assert property (@(posedge clk) disable iff (rst)
    tok[TABLE_DEPTH].act |-> (state == ST_WAIT))
    else $error("query token left the chain outside of a query");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (count != '0) == link[1].valid)
    else $error("first cell validity disagrees with entry count");

endmodule
